// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: shared package
// Register map, default sizes, the control group of the sorting cells and the
// window length clamp used by the configuration block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default build sizes.
  localparam int DEF_WINDOW_MAX   = 64;
  localparam int DEF_SAMPLE_WIDTH = 32;

  // Configuration port layout.
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int WSIZE_W = 7;

  // Register indexes (taken from paddr[2]).
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Reset value of the window size register.
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic step;    // an item is taken this cycle
    logic flush;   // the item restarts the window
    logic retire;  // the window is full, so the oldest sample leaves
    logic clear;   // a configuration write empties the window
  } cell_ctrl_t;

  // Effective window length: zero counts as one, large values saturate.
  function automatic int clamp_window(input logic [WSIZE_W-1:0] ws, input int wmax);
    int k;
    k = int'(ws);
    if (k < 1) begin
      k = 1;
    end
    if (k > wmax) begin
      k = wmax;
    end
    return k;
  endfunction

endpackage

// ===== hdl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: sorting cell
// One slot of the sorted window. It holds a sample, its age and a valid bit,
// and in each step closes the gap left by the retired sample and opens one
// for the new sample, using only its two neighbours.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SW = 32,
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  logic signed [SW-1:0] sample,
  input  logic signed [SW-1:0] oldest,
  // State of the cell to the right.
  input  logic                 nb_valid,
  input  logic signed [SW-1:0] nb_value,
  input  logic [AW-1:0]        nb_age,
  // Compacted entry of the cell to the left.
  input  logic                 pc_valid,
  input  logic signed [SW-1:0] pc_value,
  input  logic [AW-1:0]        pc_age,
  input  logic                 pc_gt,
  // Own state, seen by the left neighbour and the taps.
  output logic                 q_valid,
  output logic signed [SW-1:0] q_value,
  output logic [AW-1:0]        q_age,
  // Own compacted entry, seen by the right neighbour.
  output logic                 c_valid,
  output logic signed [SW-1:0] c_value,
  output logic [AW-1:0]        c_age,
  output logic                 c_gt
);
  import swm_pkg::*;

  logic                 valid_r, valid_nxt;
  logic signed [SW-1:0] value_r, value_nxt;
  logic [AW-1:0]        age_r, age_nxt;
  logic                 own_valid;
  logic                 nb_eff_valid;
  logic                 shift_in;

  assign q_valid = valid_r;
  assign q_value = value_r;
  assign q_age   = age_r;

  // A restart makes the whole row look empty for this step.
  assign own_valid    = valid_r & ~ctrl.flush;
  assign nb_eff_valid = nb_valid & ~ctrl.flush;

  // The retired sample is the first of its equals, so every cell at or to the
  // right of it holds a value no smaller than it and takes its right neighbour.
  assign shift_in = ctrl.retire & own_valid & (value_r >= oldest);

  always_comb begin
    if (shift_in) begin
      c_valid = nb_eff_valid;
      c_value = nb_value;
      c_age   = nb_age;
    end else begin
      c_valid = own_valid;
      c_value = value_r;
      c_age   = age_r;
    end
    c_gt = ~c_valid | (c_value > sample);
  end

  // Insert the new sample after all entries that do not exceed it.
  always_comb begin
    if (c_gt) begin
      if (!pc_gt) begin
        valid_nxt = 1'b1;
        value_nxt = sample;
        age_nxt   = '0;
      end else begin
        valid_nxt = pc_valid;
        value_nxt = pc_value;
        age_nxt   = pc_age + AW'(1);
      end
    end else begin
      valid_nxt = c_valid;
      value_nxt = c_value;
      age_nxt   = c_age + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

// ===== hdl/swm_cfg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: configuration registers
// APB-style register port holding the window size, and the values derived
// from it: effective length, median tap positions and the age of the next
// sample to retire.
// ----------------------------------------------------------------------------
module swm_cfg #(
  parameter int WINDOW_MAX = 64,
  parameter int KW = 7,
  parameter int AW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]   paddr,
  input  logic [swm_pkg::DATA_W-1:0]   pwdata,
  output logic [swm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic                         clear,
  output logic [KW-1:0]                k_len,
  output logic                         k_one,
  output logic [AW-1:0]                age_tail,
  output logic [AW-1:0]                tap_lo,
  output logic [AW-1:0]                tap_hi
);
  import swm_pkg::*;

  logic [WSIZE_W-1:0] wsize_r, wsize_nxt;
  logic [KW-1:0]      k_r;
  logic               k_one_r;
  logic [AW-1:0]      age_tail_r, tap_lo_r, tap_hi_r;
  logic               wr_en;
  int                 k_new;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_WINDOW_SIZE);
  assign clear  = wr_en;

  // Value the register takes at this edge.
  always_comb begin
    if (!rst_n) begin
      wsize_nxt = WSIZE_RESET;
    end else if (wr_en) begin
      wsize_nxt = pwdata[WSIZE_W-1:0];
    end else begin
      wsize_nxt = wsize_r;
    end
    k_new = clamp_window(wsize_nxt, WINDOW_MAX);
  end

  // Register and its derived values.
  always_ff @(posedge clk) begin
    if (!rst_n || wr_en) begin
      wsize_r    <= wsize_nxt;
      k_r        <= KW'(k_new);
      k_one_r    <= (k_new == 1);
      age_tail_r <= AW'(k_new - 2);
      tap_lo_r   <= AW'((k_new - 1) >> 1);
      tap_hi_r   <= AW'(k_new >> 1);
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) begin
      prdata = DATA_W'(wsize_r);
    end
  end

  assign k_len    = k_r;
  assign k_one    = k_one_r;
  assign age_tail = age_tail_r;
  assign tap_lo   = tap_lo_r;
  assign tap_hi   = tap_hi_r;

endmodule

// ===== hdl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: top level
// Running median over the last k signed samples, kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_valid/in_ready with in_sample and in_restart; results
//   leave on out_valid/out_ready as out_median_doubled, twice the median of
//   the window (the sum of the two middle samples for an even window).
//   No result is given until k samples have arrived since reset, a restart
//   or a write of the window size register; after that every item gives one.
//   in_restart empties the window before its own sample is taken.
//   Each result is taken from the row taps into the output register.
//   Throughput: one item per cycle while out_ready holds. The sorted row
//   of cells updates every cell at once, and the sample to retire next is
//   prefetched in the same step, so the row itself never holds an item back.
//   Stalls: a finished result waits in the output register; one more result
//   waits in the row, and in_ready drops only when both are held.
//   Reset: window size 3, window empty, no result pending. The window size
//   register is at byte address 0 of the APB-style port; writing it empties
//   the window and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW_MAX   = swm_pkg::DEF_WINDOW_MAX,
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH:0]   out_median_doubled,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]     paddr,
  input  logic [swm_pkg::DATA_W-1:0]     pwdata,
  output logic [swm_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import swm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // Configuration.
  logic          cfg_clear;
  logic [KW-1:0] k_len;
  logic          k_one;
  logic [AW-1:0] age_tail, tap_lo, tap_hi;

  swm_cfg #(
    .WINDOW_MAX (WINDOW_MAX),
    .KW         (KW),
    .AW         (AW)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .clear    (cfg_clear),
    .k_len    (k_len),
    .k_one    (k_one),
    .age_tail (age_tail),
    .tap_lo   (tap_lo),
    .tap_hi   (tap_hi)
  );

  // Control state.
  logic                 accept;
  logic                 full;
  logic                 emit;
  logic [KW-1:0]        fill_r, fill_nxt, fill_base;
  logic signed [SW-1:0] oldest_r, oldest_nxt;
  logic                 pend_r;
  logic                 load;
  logic                 out_valid_r;
  logic signed [SW:0]   median_r;
  cell_ctrl_t           ctrl;

  assign load     = pend_r & (~out_valid_r | out_ready);
  assign in_ready = ~pend_r | load;
  assign accept   = in_valid & in_ready;

  // Fill tracking: the window is full once k samples are held.
  always_comb begin
    fill_base = in_restart ? '0 : fill_r;
    full      = (fill_base == k_len);
    if (full) begin
      fill_nxt = fill_base;
      emit     = 1'b1;
    end else begin
      fill_nxt = fill_base + KW'(1);
      emit     = (fill_nxt == k_len);
    end
  end

  always_comb begin
    ctrl.step   = accept;
    ctrl.flush  = in_restart;
    ctrl.retire = full;
    ctrl.clear  = cfg_clear;
  end

  // Row of sorting cells; entry WINDOW_MAX of the right-hand arrays and entry 0
  // of the left-hand arrays are the empty ends of the row.
  logic                 q_valid [WINDOW_MAX+1];
  logic signed [SW-1:0] q_value [WINDOW_MAX+1];
  logic [AW-1:0]        q_age   [WINDOW_MAX+1];
  logic                 c_valid [WINDOW_MAX+1];
  logic signed [SW-1:0] c_value [WINDOW_MAX+1];
  logic [AW-1:0]        c_age   [WINDOW_MAX+1];
  logic                 c_gt    [WINDOW_MAX+1];

  assign q_valid[WINDOW_MAX] = 1'b0;
  assign q_value[WINDOW_MAX] = '0;
  assign q_age[WINDOW_MAX]   = '0;
  assign c_valid[0]          = 1'b0;
  assign c_value[0]          = '0;
  assign c_age[0]            = '0;
  assign c_gt[0]             = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .SW (SW),
      .AW (AW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sample   (in_sample),
      .oldest   (oldest_r),
      .nb_valid (q_valid[i+1]),
      .nb_value (q_value[i+1]),
      .nb_age   (q_age[i+1]),
      .pc_valid (c_valid[i]),
      .pc_value (c_value[i]),
      .pc_age   (c_age[i]),
      .pc_gt    (c_gt[i]),
      .q_valid  (q_valid[i]),
      .q_value  (q_value[i]),
      .q_age    (q_age[i]),
      .c_valid  (c_valid[i+1]),
      .c_value  (c_value[i+1]),
      .c_age    (c_age[i+1]),
      .c_gt     (c_gt[i+1])
    );
  end

  // Taps: the sample that retires at the next full step, and the middle pair.
  logic signed [SW-1:0] next_old, mid_lo, mid_hi;

  always_comb begin
    next_old = '0;
    mid_lo   = '0;
    mid_hi   = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (q_valid[i] && (q_age[i] == age_tail)) begin
        next_old = next_old | q_value[i];
      end
      if (AW'(i) == tap_lo) begin
        mid_lo = mid_lo | q_value[i];
      end
      if (AW'(i) == tap_hi) begin
        mid_hi = mid_hi | q_value[i];
      end
    end
    oldest_nxt = k_one ? in_sample : next_old;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && emit) begin
        pend_r <= 1'b1;
      end else if (load) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register: sum of the middle pair, one bit wider than a sample.
  always_ff @(posedge clk) begin
    if (load) begin
      median_r <= (SW+1)'(mid_lo) + (SW+1)'(mid_hi);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = median_r;

endmodule
